// ===== rtl/pxaa_pkg.sv =====
// Shared types, constants and helpers of the pixel alpha adjust block.
`default_nettype none

package pxaa_pkg;

   // alpha scaling: 4096 is opaque
   localparam int ALPHA_SHIFT = 12;
   localparam logic [12:0] ALPHA_ONE = 13'h1000;

   // configuration bus geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // stream word widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [2:0] {
      MODE_ADD       = 3'd0,
      MODE_SUBTRACT  = 3'd1,
      MODE_MULTIPLY  = 3'd2,
      MODE_SCREEN    = 3'd3,
      MODE_OVERWRITE = 3'd4
   } blend_mode_type;

   typedef enum logic [2:0] {
      CSR_BLEND_MODE     = 3'd0,
      CSR_AMOUNT         = 3'd1,
      CSR_THRESHOLD_HIGH = 3'd2,
      CSR_THRESHOLD_LOW  = 3'd3,
      CSR_FILL_ENABLE    = 3'd4,
      CSR_FILL_Y         = 3'd5,
      CSR_FILL_CB        = 3'd6,
      CSR_FILL_CR        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         blend_mode;
      logic [13:0]        amount;
      logic [12:0]        threshold_high;
      logic [12:0]        threshold_low;
      logic               fill_enable;
      logic signed [15:0] fill_y;
      logic signed [15:0] fill_cb;
      logic signed [15:0] fill_cr;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] cb;
      logic signed [15:0] cr;
      logic [12:0]        alpha;
   } pixel_type;

   // after the window check
   typedef struct packed {
      pixel_type      pix;
      logic [13:0]    amount;
      blend_mode_type mode;
      logic           adjust;
   } s1_type;

   // after the arithmetic stage
   typedef struct packed {
      pixel_type      pix;
      logic [13:0]    amount;
      blend_mode_type mode;
      logic           adjust;
      logic [14:0]    product;
      logic [14:0]    sum;
      logic [12:0]    diff;
   } s2_type;

   // limit a 15-bit alpha value to 0..4096
   function automatic logic [12:0] clamp_alpha(input logic [14:0] x);
      logic [12:0] r;
      if (x > {2'b00, ALPHA_ONE}) begin
         r = ALPHA_ONE;
      end else begin
         r = x[12:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_alpha_adjust.sv =====
// Throughput: one word per cycle unless rsp_tready holds the output; an accepted req word
// passes three register stages (window check, multiplier, clamp and select) to the rsp
// output register, each stage with its own valid bit, so bubbles close up under stalls.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// register defaults (add mode, amount 2048, window 0..4096, fill off, fill colour 0).
`default_nettype none

module pixel_alpha_adjust (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // APB-style configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [pxaa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [pxaa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [pxaa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready,
   // input words
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // pixel_y[15:0], pixel_cb[31:16], pixel_cr[47:32], pixel_alpha[60:48], zero[63:61]
   input  wire logic [pxaa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result words
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_y[15:0], out_cb[31:16], out_cr[47:32], out_alpha[60:48], zero[63:61]
   output logic      [pxaa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   pxaa_pkg::cfg_type   cfg;
   pxaa_pkg::pixel_type req_pix;
   pxaa_pkg::pixel_type rsp_pix;
   pxaa_pkg::s1_type    s1_data;
   pxaa_pkg::s2_type    s2_data;
   logic                s1_valid;
   logic                s1_ready;
   logic                s2_valid;
   logic                s2_ready;

   // unpack the input word
   assign req_pix.y     = req_tdata[15:0];
   assign req_pix.cb    = req_tdata[31:16];
   assign req_pix.cr    = req_tdata[47:32];
   assign req_pix.alpha = req_tdata[60:48];

   pxaa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pxaa_window u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (req_pix),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   pxaa_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   pxaa_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (rsp_pix)
   );

   // pack the result word
   assign rsp_tdata = {3'b000, rsp_pix.alpha, rsp_pix.cr, rsp_pix.cb, rsp_pix.y};

endmodule

`default_nettype wire

// ===== rtl/pxaa_csr.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none

module pxaa_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pxaa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pxaa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pxaa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output pxaa_pkg::cfg_type                      cfg
);

   pxaa_pkg::cfg_type       cfg_ff;
   pxaa_pkg::cfg_type       cfg_in;
   pxaa_pkg::csr_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = pxaa_pkg::csr_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // register update on the access cycle of a write
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            pxaa_pkg::CSR_BLEND_MODE:     cfg_in.blend_mode     = csr_pwdata[2:0];
            pxaa_pkg::CSR_AMOUNT:         cfg_in.amount         = csr_pwdata[13:0];
            pxaa_pkg::CSR_THRESHOLD_HIGH: cfg_in.threshold_high = csr_pwdata[12:0];
            pxaa_pkg::CSR_THRESHOLD_LOW:  cfg_in.threshold_low  = csr_pwdata[12:0];
            pxaa_pkg::CSR_FILL_ENABLE:    cfg_in.fill_enable    = csr_pwdata[0];
            pxaa_pkg::CSR_FILL_Y:         cfg_in.fill_y         = csr_pwdata[15:0];
            pxaa_pkg::CSR_FILL_CB:        cfg_in.fill_cb        = csr_pwdata[15:0];
            pxaa_pkg::CSR_FILL_CR:        cfg_in.fill_cr        = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_mode     <= 3'(pxaa_pkg::MODE_ADD);
         cfg_ff.amount         <= 14'd2048;
         cfg_ff.threshold_high <= pxaa_pkg::ALPHA_ONE;
         cfg_ff.threshold_low  <= 13'd0;
         cfg_ff.fill_enable    <= 1'b0;
         cfg_ff.fill_y         <= 16'sd0;
         cfg_ff.fill_cb        <= 16'sd0;
         cfg_ff.fill_cr        <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero extended
   always_comb begin
      case (index)
         pxaa_pkg::CSR_BLEND_MODE:     csr_prdata = 32'(cfg_ff.blend_mode);
         pxaa_pkg::CSR_AMOUNT:         csr_prdata = 32'(cfg_ff.amount);
         pxaa_pkg::CSR_THRESHOLD_HIGH: csr_prdata = 32'(cfg_ff.threshold_high);
         pxaa_pkg::CSR_THRESHOLD_LOW:  csr_prdata = 32'(cfg_ff.threshold_low);
         pxaa_pkg::CSR_FILL_ENABLE:    csr_prdata = 32'(cfg_ff.fill_enable);
         pxaa_pkg::CSR_FILL_Y:         csr_prdata = {16'h0000, cfg_ff.fill_y};
         pxaa_pkg::CSR_FILL_CB:        csr_prdata = {16'h0000, cfg_ff.fill_cb};
         pxaa_pkg::CSR_FILL_CR:        csr_prdata = {16'h0000, cfg_ff.fill_cr};
         default:                      csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/pxaa_window.sv =====
// Stage one: window check, mode decode and fill colour substitution.
`default_nettype none

module pxaa_window (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pxaa_pkg::cfg_type cfg,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire pxaa_pkg::pixel_type in_pix,
   output logic              out_valid,
   input  wire logic         out_ready,
   output pxaa_pkg::s1_type  out_data
);

   logic                     valid_ff;
   logic                     valid_in;
   pxaa_pkg::s1_type         data_ff;
   pxaa_pkg::s1_type         data_in;
   logic [12:0]              hi;
   logic [12:0]              lo;
   logic                     active;
   logic                     fill;
   logic [13:0]              v;
   pxaa_pkg::blend_mode_type mode;
   logic                     adjust;

   assign in_ready = ~valid_ff | out_ready;
   assign mode     = pxaa_pkg::blend_mode_type'(cfg.blend_mode);

   // clamp thresholds to opaque
   assign hi = (cfg.threshold_high > pxaa_pkg::ALPHA_ONE) ? pxaa_pkg::ALPHA_ONE
                                                           : cfg.threshold_high;
   assign lo = (cfg.threshold_low > pxaa_pkg::ALPHA_ONE) ? pxaa_pkg::ALPHA_ONE
                                                          : cfg.threshold_low;

   // per-mode neutral amounts, overwrite amount limit and fill qualification
   always_comb begin
      active = (hi >= lo);
      fill   = cfg.fill_enable & (lo == 13'd0);
      v      = cfg.amount;
      case (mode)
         pxaa_pkg::MODE_ADD: begin
            if (v == 14'd0) active = 1'b0;
         end
         pxaa_pkg::MODE_SUBTRACT: begin
            if (v == 14'd0) active = 1'b0;
            fill = 1'b0;
         end
         pxaa_pkg::MODE_MULTIPLY: begin
            if (v == {1'b0, pxaa_pkg::ALPHA_ONE}) active = 1'b0;
            fill = 1'b0;
         end
         pxaa_pkg::MODE_SCREEN: begin
            if (v == 14'd0) active = 1'b0;
         end
         pxaa_pkg::MODE_OVERWRITE: begin
            if (v > {1'b0, pxaa_pkg::ALPHA_ONE}) v = {1'b0, pxaa_pkg::ALPHA_ONE};
         end
         default: begin
            active = 1'b0;
         end
      endcase
   end

   assign adjust = active & (in_pix.alpha >= lo) & (in_pix.alpha <= hi);

   // build the stage word
   always_comb begin
      data_in.pix    = in_pix;
      data_in.amount = v;
      data_in.mode   = mode;
      data_in.adjust = adjust;
      if (adjust & fill & (in_pix.alpha == 13'd0)) begin
         data_in.pix.y  = cfg.fill_y;
         data_in.pix.cb = cfg.fill_cb;
         data_in.pix.cr = cfg.fill_cr;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/pxaa_blend.sv =====
// Stage two: product, sum and saturating difference of alpha and amount.
`default_nettype none

module pxaa_blend (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire pxaa_pkg::s1_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output pxaa_pkg::s2_type out_data
);

   logic             valid_ff;
   logic             valid_in;
   pxaa_pkg::s2_type data_ff;
   pxaa_pkg::s2_type data_in;
   logic [26:0]      product_full;
   logic [13:0]      diff_full;

   assign in_ready = ~valid_ff | out_ready;

   // a*v fits in 27 bits; keep the part above the scaling shift
   assign product_full = 27'(in_data.pix.alpha) * 27'(in_data.amount);
   assign diff_full    = {1'b0, in_data.pix.alpha} - in_data.amount;

   always_comb begin
      data_in.pix     = in_data.pix;
      data_in.amount  = in_data.amount;
      data_in.mode    = in_data.mode;
      data_in.adjust  = in_data.adjust;
      data_in.product = product_full[26:pxaa_pkg::ALPHA_SHIFT];
      data_in.sum     = 15'(in_data.pix.alpha) + 15'(in_data.amount);
      data_in.diff    = ({1'b0, in_data.pix.alpha} > in_data.amount) ? diff_full[12:0]
                                                                     : 13'd0;
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/pxaa_clamp.sv =====
// Stage three: mode select, clamp to 0..4096 in add, multiply and screen modes, and the output register.
`default_nettype none

module pxaa_clamp (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire pxaa_pkg::s2_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output pxaa_pkg::pixel_type out_pix
);

   logic                valid_ff;
   logic                valid_in;
   pxaa_pkg::pixel_type data_ff;
   pxaa_pkg::pixel_type data_in;
   logic [14:0]         screen;

   assign in_ready = ~valid_ff | out_ready;

   // product never exceeds the amount here, so no underflow
   assign screen = in_data.sum - in_data.product;

   always_comb begin
      data_in = in_data.pix;
      if (in_data.adjust) begin
         case (in_data.mode)
            pxaa_pkg::MODE_ADD:      data_in.alpha = pxaa_pkg::clamp_alpha(in_data.sum);
            pxaa_pkg::MODE_SUBTRACT: data_in.alpha = in_data.diff;
            pxaa_pkg::MODE_MULTIPLY: data_in.alpha = pxaa_pkg::clamp_alpha(in_data.product);
            pxaa_pkg::MODE_SCREEN:   data_in.alpha = pxaa_pkg::clamp_alpha(screen);
            default:                 data_in.alpha = in_data.amount[12:0];
         endcase
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = data_ff;

endmodule

`default_nettype wire
